FILE: design/mxl_pkg.sv
// ----------------------------------------------------------------------------
// mxl_pkg
// Shared types and codes for the Montgomery XZ ladder multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
package mxl_pkg;
   localparam int unsigned WordBits = 64;

   // field unit operation codes
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_RED = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_A24     = 1'b1;
endpackage
`default_nettype wire

FILE: design/mxl_field_unit.sv
// ----------------------------------------------------------------------------
// mxl_field_unit
// Shared modular unit: add and subtract straight from idle, multiply by
// double-and-add one bit per cycle, reduce by restoring shift-subtract.
// ----------------------------------------------------------------------------
`default_nettype none
module mxl_field_unit #(
   parameter int unsigned FIELD_BITS = 63
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire mxl_pkg::op_type       op,
   input  wire logic [FIELD_BITS-1:0] prime,
   input  wire logic [FIELD_BITS-1:0] opa,
   input  wire logic [FIELD_BITS-1:0] opb,
   output logic                       done,
   output logic [FIELD_BITS-1:0]      result
);
   import mxl_pkg::*;

   localparam int unsigned CntBits = $clog2(FIELD_BITS + 1);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED} state_type;

   state_type             state_ff, state_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [FIELD_BITS-1:0] a_ff, a_in;
   logic [FIELD_BITS-1:0] b_ff, b_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   logic [FIELD_BITS:0]   dbl;
   logic [FIELD_BITS-1:0] dbl_r;
   logic [FIELD_BITS:0]   rsh;

   // one modular add of operands x and y (both below prime)
   function automatic logic [FIELD_BITS-1:0] madd(input logic [FIELD_BITS-1:0] x,
                                                  input logic [FIELD_BITS-1:0] y,
                                                  input logic [FIELD_BITS-1:0] p);
      logic [FIELD_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, p}) begin
         s = s - {1'b0, p};
      end
      return s[FIELD_BITS-1:0];
   endfunction

   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, prime}) ? FIELD_BITS'(dbl - {1'b0, prime})
                                     : dbl[FIELD_BITS-1:0];
      rsh   = {acc_ff, b_ff[FIELD_BITS-1]};
      state_in = state_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (op)
                  OP_ADD: begin
                     acc_in  = madd(opa, opb, prime);
                     done_in = 1'b1;
                  end
                  OP_SUB: begin
                     acc_in  = (opa >= opb) ? FIELD_BITS'(opa - opb)
                                            : FIELD_BITS'(opa + (prime - opb));
                     done_in = 1'b1;
                  end
                  OP_MUL: begin
                     acc_in   = '0;
                     a_in     = opa;
                     b_in     = opb;
                     cnt_in   = CntBits'(FIELD_BITS);
                     state_in = S_MUL;
                  end
                  default: begin
                     acc_in   = '0;
                     b_in     = opa;
                     cnt_in   = CntBits'(FIELD_BITS);
                     state_in = S_RED;
                  end
               endcase
            end
         end
         // double the partial product, add a when the next bit of b is set
         S_MUL: begin
            if (b_ff[FIELD_BITS-1]) begin
               acc_in = madd(dbl_r, a_ff, prime);
            end else begin
               acc_in = dbl_r;
            end
            b_in   = {b_ff[FIELD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         // restoring remainder: shift in one bit, subtract when it fits
         S_RED: begin
            acc_in = (rsh >= {1'b0, prime}) ? FIELD_BITS'(rsh - {1'b0, prime})
                                            : rsh[FIELD_BITS-1:0];
            b_in   = {b_ff[FIELD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

`ifndef NO_ASSERTIONS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == S_IDLE) else $error("done outside idle");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> cnt_ff != '0) else $error("counter ran out");
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> acc_ff < prime) else $error("result not reduced");
`endif
endmodule
`default_nettype wire

FILE: design/montgomery_xz_ladder_mul.sv
// ----------------------------------------------------------------------------
// montgomery_xz_ladder_mul
// XZ scalar multiplication on a Montgomery curve by the ladder.
// ----------------------------------------------------------------------------
// Use: write modulus (index 0) and a24 (index 1) on the csr_ port while idle,
// then present one item on req_ (tdata: point_x, point_z, scalar from bit 0).
// req_tready is high only while the block is idle; one item is worked at a
// time. The result (tdata: out_x, out_z) is held on rsp_ until taken; a
// stalled receiver stalls the block, which waits with the result.
// Sequencing: the sequencer issues each field operation to one shared unit,
// whose multiplier loop dominates the run time; each program segment ends
// with a commit state (S_NEXT). An item costs three reductions,
// a doubling (5 multiplies, 4 add/sub), then per ladder bit between the
// leading one and bit 0 a differential add and a doubling (11 multiplies,
// 10 add/sub); bit 0 takes one add or doubling. Scalars 0 and 1 finish
// after the reductions. Reset returns modulus to 3, a24 to 0, empties the
// result register and makes the block idle.
// ----------------------------------------------------------------------------
`default_nettype none
module montgomery_xz_ladder_mul #(
   parameter int unsigned FIELD_BITS  = 63,
   parameter int unsigned SCALAR_BITS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_index,
   input  wire logic [FIELD_BITS-1:0] csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // point_x, point_z, scalar from bit 0 up, zero fill to bytes
   input  wire logic [((2*FIELD_BITS+SCALAR_BITS+7)/8)*8-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_x, out_z from bit 0 up, zero fill to bytes
   output logic [((2*FIELD_BITS+7)/8)*8-1:0] rsp_tdata
);
   import mxl_pkg::*;

   localparam int unsigned RspBits = ((2*FIELD_BITS+7)/8)*8;
   localparam int unsigned SBits   = $clog2(SCALAR_BITS);
   localparam int unsigned NRegs   = 16;
   localparam int unsigned RBits   = 4;

   // register file slots
   localparam logic [RBits-1:0] R_X1 = 4'd0,  R_Z1 = 4'd1,  R_XA = 4'd2,
                                R_ZA = 4'd3,  R_XB = 4'd4,  R_ZB = 4'd5,
                                R_A24 = 4'd6, R_T0 = 4'd7,  R_T1 = 4'd8,
                                R_T2 = 4'd9,  R_T3 = 4'd10, R_T4 = 4'd11,
                                R_T5 = 4'd12, R_T6 = 4'd13, R_T7 = 4'd14,
                                R_T8 = 4'd15;

   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_WAIT, S_NEXT, S_OUT
   } state_type;

   // microprogram: op, dst, srca, srcb
   typedef struct packed {
      op_type           op;
      logic [RBits-1:0] dst;
      logic [RBits-1:0] sa;
      logic [RBits-1:0] sb;
   } uop_type;

   // program segments
   typedef enum logic [2:0] {
      G_RED, G_DBL_A, G_DBL_B, G_DADD_BA, G_DADD_AB, G_COPY_A
   } seg_type;

   state_type             state_ff, state_in;
   seg_type               seg_ff, seg_in;
   logic [4:0]            pc_ff, pc_in;
   logic [FIELD_BITS-1:0] rf_ff [NRegs];
   logic [FIELD_BITS-1:0] prime_ff, a24_ff;
   logic [SCALAR_BITS-1:0] k_ff, k_in;
   logic [SBits-1:0]      bit_ff, bit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RspBits-1:0]    rsp_data_ff, rsp_data_in;

   logic [FIELD_BITS-1:0] pt_x, pt_z, csr_val, prime_eff;
   logic [SCALAR_BITS-1:0] k_new;
   uop_type               uop;
   logic [4:0]            seg_len;
   logic                  fu_start, fu_done;
   logic [FIELD_BITS-1:0] fu_result;
   logic [SBits-1:0]      top;
   logic                  last_bit;

   assign pt_x    = req_tdata[FIELD_BITS-1:0];
   assign pt_z    = req_tdata[2*FIELD_BITS-1:FIELD_BITS];
   assign k_new   = req_tdata[2*FIELD_BITS+SCALAR_BITS-1:2*FIELD_BITS];
   assign csr_val = csr_wdata;
   assign prime_eff = (prime_ff < FIELD_BITS'(3)) ? FIELD_BITS'(3) : prime_ff;

   // leading one of the scalar
   always_comb begin
      top = '0;
      for (int i = 0; i < SCALAR_BITS; i++) begin
         if (k_ff[i]) begin
            top = SBits'(i);
         end
      end
   end

   // microcode: doubling of (sx:sz) into T6:T7, leaving T1 and T8 alone
   function automatic uop_type dbl_uop(input logic [4:0] pc,
                                       input logic [RBits-1:0] sx,
                                       input logic [RBits-1:0] sz);
      uop_type u;
      u = '{OP_ADD, R_T0, sx, sz};
      case (pc)
         5'd0: u = '{OP_ADD, R_T0, sx, sz};
         5'd1: u = '{OP_MUL, R_T2, R_T0, R_T0};
         5'd2: u = '{OP_SUB, R_T0, sx, sz};
         5'd3: u = '{OP_MUL, R_T3, R_T0, R_T0};
         5'd4: u = '{OP_SUB, R_T4, R_T2, R_T3};
         5'd5: u = '{OP_MUL, R_T5, R_A24, R_T4};
         5'd6: u = '{OP_ADD, R_T5, R_T3, R_T5};
         5'd7: u = '{OP_MUL, R_T7, R_T4, R_T5};
         5'd8: u = '{OP_MUL, R_T6, R_T2, R_T3};
         default: u = '{OP_ADD, R_T0, sx, sz};
      endcase
      return u;
   endfunction

   // microcode: Q + R with difference P, into T8:T1 (x:z)
   function automatic uop_type dadd_uop(input logic [4:0] pc,
                                        input logic [RBits-1:0] xr,
                                        input logic [RBits-1:0] zr,
                                        input logic [RBits-1:0] xq,
                                        input logic [RBits-1:0] zq);
      uop_type u;
      u = '{OP_ADD, R_T0, xq, zq};
      case (pc)
         5'd0:  u = '{OP_ADD, R_T0, xq, zq};
         5'd1:  u = '{OP_SUB, R_T1, xq, zq};
         5'd2:  u = '{OP_ADD, R_T2, xr, zr};
         5'd3:  u = '{OP_SUB, R_T3, xr, zr};
         5'd4:  u = '{OP_MUL, R_T4, R_T3, R_T0};
         5'd5:  u = '{OP_MUL, R_T5, R_T2, R_T1};
         5'd6:  u = '{OP_ADD, R_T0, R_T4, R_T5};
         5'd7:  u = '{OP_SUB, R_T1, R_T4, R_T5};
         5'd8:  u = '{OP_MUL, R_T0, R_T0, R_T0};
         5'd9:  u = '{OP_MUL, R_T8, R_Z1, R_T0};
         5'd10: u = '{OP_MUL, R_T1, R_T1, R_T1};
         5'd11: u = '{OP_MUL, R_T1, R_X1, R_T1};
         default: u = '{OP_ADD, R_T0, xq, zq};
      endcase
      return u;
   endfunction

   // select the current micro-op
   always_comb begin
      uop     = '{OP_RED, R_X1, R_X1, R_X1};
      seg_len = 5'd0;
      case (seg_ff)
         G_RED: begin
            seg_len = 5'd3;
            case (pc_ff)
               5'd0: uop = '{OP_RED, R_X1, R_X1, R_X1};
               5'd1: uop = '{OP_RED, R_Z1, R_Z1, R_Z1};
               default: uop = '{OP_RED, R_A24, R_A24, R_A24};
            endcase
         end
         G_DBL_A: begin
            seg_len = 5'd9;
            uop = dbl_uop(pc_ff, R_XA, R_ZA);
         end
         G_DBL_B: begin
            seg_len = 5'd9;
            uop = dbl_uop(pc_ff, R_XB, R_ZB);
         end
         G_DADD_BA: begin
            seg_len = 5'd12;
            uop = dadd_uop(pc_ff, R_XA, R_ZA, R_XB, R_ZB);
         end
         G_DADD_AB: begin
            seg_len = 5'd12;
            uop = dadd_uop(pc_ff, R_XB, R_ZB, R_XA, R_ZA);
         end
         default: begin
            seg_len = 5'd0;
         end
      endcase
   end

   mxl_field_unit #(.FIELD_BITS(FIELD_BITS)) u_fu (
      .clock  (clock),
      .reset  (reset),
      .start  (fu_start),
      .op     (uop.op),
      .prime  (prime_eff),
      .opa    (rf_ff[uop.sa]),
      .opb    (rf_ff[uop.sb]),
      .done   (fu_done),
      .result (fu_result)
   );

   assign fu_start   = (state_ff == S_ISSUE);
   assign req_tready = (state_ff == S_IDLE);
   assign last_bit   = (bit_ff == '0);

   // Ladder sequencing. A ladder step: dadd into T8:T1, then a doubling of
   // the selected point into T6:T7; results are copied at segment end.
   // bit_ff counts the ladder bit being handled.
   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      pc_in        = pc_ff;
      k_in         = k_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               k_in     = k_new;
               seg_in   = G_RED;
               pc_in    = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (fu_done) begin
               if (pc_ff == seg_len - 5'd1) begin
                  pc_in    = '0;
                  state_in = S_NEXT;
               end else begin
                  pc_in    = pc_ff + 5'd1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_NEXT: begin
            state_in = S_ISSUE;
            case (seg_ff)
               G_RED: begin
                  if (k_ff == '0 || k_ff == SCALAR_BITS'(1)) begin
                     state_in = S_OUT;
                  end else begin
                     bit_in = top;
                     seg_in = G_DBL_A;
                  end
               end
               G_DBL_A, G_DBL_B: begin
                  if (bit_ff == top) begin
                     bit_in = top - SBits'(1);
                     if (bit_in == '0) begin
                        seg_in = k_ff[0] ? G_DADD_AB : G_DBL_A;
                     end else begin
                        seg_in = G_DADD_BA;
                     end
                  end else if (last_bit) begin
                     state_in = S_OUT;
                  end else begin
                     bit_in = bit_ff - SBits'(1);
                     if (bit_in == '0) begin
                        seg_in = k_ff[0] ? G_DADD_AB : G_DBL_A;
                     end else begin
                        seg_in = G_DADD_BA;
                     end
                  end
               end
               G_DADD_BA: begin
                  seg_in = k_ff[bit_ff] ? G_DBL_B : G_DBL_A;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (k_ff == '0) begin
                  rsp_data_in = RspBits'({FIELD_BITS'(0), FIELD_BITS'(1)});
               end else if (k_ff == SCALAR_BITS'(1)) begin
                  rsp_data_in = RspBits'({rf_ff[R_Z1], rf_ff[R_X1]});
               end else begin
                  rsp_data_in = RspBits'({rf_ff[R_ZA], rf_ff[R_XA]});
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prime_ff     <= FIELD_BITS'(3);
         a24_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_MODULUS) begin
            prime_ff <= csr_val;
         end
         if (csr_we && csr_index == CSR_A24) begin
            a24_ff <= csr_val;
         end
      end
      seg_ff      <= seg_in;
      pc_ff       <= pc_in;
      k_ff        <= k_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register file writes: load, unit results, segment commits
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         rf_ff[R_X1]  <= pt_x;
         rf_ff[R_Z1]  <= pt_z;
         rf_ff[R_A24] <= a24_ff;
      end else if (state_ff == S_WAIT && fu_done) begin
         rf_ff[uop.dst] <= fu_result;
      end else if (state_ff == S_NEXT) begin
         case (seg_ff)
            G_RED: begin
               rf_ff[R_XA] <= rf_ff[R_X1];
               rf_ff[R_ZA] <= rf_ff[R_Z1];
            end
            G_DBL_A: begin
               if (bit_ff == top) begin
                  rf_ff[R_XB] <= rf_ff[R_T6];
                  rf_ff[R_ZB] <= rf_ff[R_T7];
               end else begin
                  rf_ff[R_XA] <= rf_ff[R_T6];
                  rf_ff[R_ZA] <= rf_ff[R_T7];
                  if (!last_bit) begin
                     rf_ff[R_XB] <= rf_ff[R_T8];
                     rf_ff[R_ZB] <= rf_ff[R_T1];
                  end
               end
            end
            G_DBL_B: begin
               rf_ff[R_XA] <= rf_ff[R_T8];
               rf_ff[R_ZA] <= rf_ff[R_T1];
               rf_ff[R_XB] <= rf_ff[R_T6];
               rf_ff[R_ZB] <= rf_ff[R_T7];
            end
            G_DADD_AB: begin
               rf_ff[R_XA] <= rf_ff[R_T8];
               rf_ff[R_ZA] <= rf_ff[R_T1];
            end
            default: begin
               rf_ff[R_T8] <= rf_ff[R_T8];
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result dropped");
   a_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |=> state_ff == S_WAIT) else $error("issue lost");
`endif
endmodule
`default_nettype wire
